// ----- sv/cnt_pkg.sv -----
// Package for the Carmichael number test unit.
// Holds widths, the controller state type and the controller/datapath command structs.
package cnt_pkg;

   localparam int NBits = 16;
   localparam int MapDepth = 1 << NBits;
   localparam int CntBits = $clog2(NBits);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_SIEVE_RD,
      ST_SIEVE_CHK,
      ST_SIEVE_MARK,
      ST_IDLE,
      ST_LOOKUP,
      ST_BASE,
      ST_SQUARE,
      ST_MULT,
      ST_CHECK,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic clear_step;      // advance the clearing address
      logic sieve_init;      // i = 2
      logic sieve_next_i;    // i = i + 1
      logic mark_init;       // j = 2i
      logic mark_step;       // write map[j] = 1, j = j + i
      logic load_n;          // capture the number, read map[n]
      logic base_init;       // a = 2
      logic base_next;       // a = a + 1
      logic pow_init;        // acc = 1, bit = 15
      logic mult_sel;        // multiply acc by a instead of squaring it
      logic do_square;       // acc = acc*acc mod n
      logic do_mult;         // acc = acc*a mod n (if exponent bit set)
      logic mod_start;       // launch reduction
      logic set_result;      // result = carmichael flag
      logic result_val;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic i_done;          // i reached the end of the table
      logic map_bit;         // registered read data
      logic j_done;          // j beyond the table
      logic n_small;         // n < 4 guard not needed; composite implies n >= 4
      logic base_done;       // a + 1 >= n
      logic bit_last;        // exponent bit index is zero
      logic mod_busy;
      logic pow_ok;          // acc == a
   } status_type;

endpackage

// ----- sv/cnt_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module cnt_ram #(
   parameter int Width = 1,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

// ----- sv/cnt_modred.sv -----
// Bit-serial modular reduction of a 32-bit product by a 16-bit modulus.
// Uses cnt_pkg for widths.
module cnt_modred (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [2*cnt_pkg::NBits-1:0] dividend,
   input  logic [cnt_pkg::NBits-1:0]   modulus,
   output logic                       busy,
   output logic [cnt_pkg::NBits-1:0]   remainder
);
   localparam int W = 2 * cnt_pkg::NBits;

   logic [W-1:0]              quo_ff, quo_in;
   logic [cnt_pkg::NBits:0]   rem_ff, rem_in;
   logic [$clog2(W+1)-1:0]    cnt_ff, cnt_in;
   logic [cnt_pkg::NBits+1:0] trial;

   assign busy = (cnt_ff != '0);
   assign remainder = rem_ff[cnt_pkg::NBits-1:0];

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      trial = {rem_ff, quo_ff[W-1]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = ($clog2(W+1))'(W);
      end else if (busy) begin
         // shift one dividend bit in, subtract when it fits
         if (trial >= {2'b00, modulus}) begin
            rem_in = (cnt_pkg::NBits+1)'(trial - {2'b00, modulus});
         end else begin
            rem_in = trial[cnt_pkg::NBits:0];
         end
         quo_in = {quo_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end
endmodule

// ----- sv/cnt_datapath.sv -----
// Datapath: composite map, sieve counters, Fermat base loop, modular exponentiation.
// Uses cnt_pkg, cnt_ram and cnt_modred.
module cnt_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  cnt_pkg::cmd_type         cmd,
   input  logic [cnt_pkg::NBits-1:0] req_number,
   output cnt_pkg::status_type      status,
   output logic [cnt_pkg::NBits-1:0] rsp_tested_number,
   output logic                     rsp_is_carmichael,
   output logic                     rsp_valid
);
   localparam int N = cnt_pkg::NBits;

   logic [N-1:0]   clr_ff, clr_in;
   logic [N:0]     i_ff, i_in;
   logic [N:0]     j_ff, j_in;
   logic [N-1:0]   n_ff, n_in;
   logic [N-1:0]   a_ff, a_in;
   logic [N-1:0]   acc_ff, acc_in;
   logic [cnt_pkg::CntBits-1:0] bit_ff, bit_in;
   logic           res_ff, res_in;
   logic           val_ff, val_in;

   logic           ram_we, ram_wd, ram_rd;
   logic [N-1:0]   ram_addr;
   logic [N-1:0]   mr_rem, mul_src;
   logic           mr_busy;
   logic [2*N-1:0] prod;

   cnt_ram #(.Width(1), .Depth(cnt_pkg::MapDepth)) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wd),
      .rd_data (ram_rd)
   );

   assign mul_src = cmd.mult_sel ? a_ff : acc_ff;
   assign prod    = acc_ff * mul_src;

   cnt_modred u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (prod),
      .modulus   (n_ff),
      .busy      (mr_busy),
      .remainder (mr_rem)
   );

   always_comb begin
      ram_we   = 1'b0;
      ram_wd   = 1'b0;
      ram_addr = i_ff[N-1:0];
      if (cmd.clear_step) begin
         ram_we   = 1'b1;
         ram_addr = clr_ff;
      end else if (cmd.mark_step) begin
         ram_we   = 1'b1;
         ram_wd   = 1'b1;
         ram_addr = j_ff[N-1:0];
      end else if (cmd.load_n) begin
         ram_addr = req_number;
      end
   end

   always_comb begin
      clr_in = clr_ff;
      i_in   = i_ff;
      j_in   = j_ff;
      n_in   = n_ff;
      a_in   = a_ff;
      acc_in = acc_ff;
      bit_in = bit_ff;
      res_in = res_ff;
      val_in = 1'b0;
      if (cmd.clear_step) clr_in = clr_ff + 1'b1;
      if (cmd.sieve_init) i_in = (N+1)'(2);
      if (cmd.sieve_next_i) i_in = i_ff + 1'b1;
      if (cmd.mark_init) j_in = {i_ff[N-1:0], 1'b0};
      if (cmd.mark_step) j_in = j_ff + i_ff;
      if (cmd.load_n) n_in = req_number;
      if (cmd.base_init) a_in = N'(2);
      if (cmd.base_next) a_in = a_ff + 1'b1;
      if (cmd.pow_init) begin
         acc_in = N'(1);
         bit_in = cnt_pkg::CntBits'(N - 1);
      end
      if (cmd.do_square) acc_in = mr_rem;
      if (cmd.do_mult) begin
         if (n_ff[bit_ff]) acc_in = mr_rem;
         bit_in = bit_ff - 1'b1;
      end
      if (cmd.set_result) res_in = cmd.result_val;
      if (cmd.set_result) val_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         val_ff <= 1'b0;
      end else begin
         clr_ff <= clr_in;
         val_ff <= val_in;
      end
      i_ff   <= i_in;
      j_ff   <= j_in;
      n_ff   <= n_in;
      a_ff   <= a_in;
      acc_ff <= acc_in;
      bit_ff <= bit_in;
      res_ff <= res_in;
   end

   always_comb begin
      status.clear_done = (clr_ff == '1);
      status.i_done     = i_ff[N];
      status.map_bit    = ram_rd;
      status.j_done     = j_ff[N];
      status.n_small    = (n_ff < N'(4));
      status.base_done  = ({1'b0, a_ff} + 1'b1 >= {1'b0, n_ff});
      status.bit_last   = (bit_ff == '0);
      status.mod_busy   = mr_busy;
      status.pow_ok     = (acc_ff == a_ff);
   end

   assign rsp_tested_number = n_ff;
   assign rsp_is_carmichael = res_ff;
   assign rsp_valid         = val_ff;
endmodule

// ----- sv/cnt_ctrl.sv -----
// Controller state machine: sieve after reset, then one Fermat test per transfer.
// Uses cnt_pkg.
module cnt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  cnt_pkg::status_type status,
   output cnt_pkg::cmd_type    cmd,
   output logic                busy
);
   cnt_pkg::state_type state_ff, state_in;
   logic               wait_ff, wait_in;   // reduction launched, awaiting result

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cnt_pkg::ST_CLEAR;
         wait_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      wait_in  = wait_ff;
      cmd      = '0;
      busy     = (state_ff != cnt_pkg::ST_IDLE);
      unique case (state_ff)
         cnt_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               cmd.sieve_init = 1'b1;
               state_in = cnt_pkg::ST_SIEVE_RD;
            end
         end
         cnt_pkg::ST_SIEVE_RD: begin
            if (status.i_done) begin
               state_in = cnt_pkg::ST_IDLE;
            end else begin
               state_in = cnt_pkg::ST_SIEVE_CHK;
            end
         end
         cnt_pkg::ST_SIEVE_CHK: begin
            if (status.map_bit) begin
               cmd.sieve_next_i = 1'b1;
               state_in = cnt_pkg::ST_SIEVE_RD;
            end else begin
               cmd.mark_init = 1'b1;
               state_in = cnt_pkg::ST_SIEVE_MARK;
            end
         end
         cnt_pkg::ST_SIEVE_MARK: begin
            if (status.j_done) begin
               cmd.sieve_next_i = 1'b1;
               state_in = cnt_pkg::ST_SIEVE_RD;
            end else begin
               cmd.mark_step = 1'b1;
            end
         end
         cnt_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load_n = 1'b1;
               state_in = cnt_pkg::ST_LOOKUP;
            end
         end
         cnt_pkg::ST_LOOKUP: begin
            // map bit for the captured number is on the read port now
            if (status.map_bit && !status.n_small) begin
               cmd.base_init = 1'b1;
               state_in = cnt_pkg::ST_BASE;
            end else begin
               cmd.set_result = 1'b1;
               state_in = cnt_pkg::ST_REPORT;
            end
         end
         cnt_pkg::ST_BASE: begin
            if (status.base_done) begin
               cmd.set_result = 1'b1;
               cmd.result_val = 1'b1;
               state_in = cnt_pkg::ST_REPORT;
            end else begin
               cmd.pow_init = 1'b1;
               wait_in = 1'b0;
               state_in = cnt_pkg::ST_SQUARE;
            end
         end
         cnt_pkg::ST_SQUARE: begin
            // launch the reduction, then take its remainder
            if (!wait_ff) begin
               cmd.mod_start = 1'b1;
               wait_in = 1'b1;
            end else if (!status.mod_busy) begin
               cmd.do_square = 1'b1;
               wait_in = 1'b0;
               state_in = cnt_pkg::ST_MULT;
            end
         end
         cnt_pkg::ST_MULT: begin
            cmd.mult_sel = 1'b1;
            if (!wait_ff) begin
               cmd.mod_start = 1'b1;
               wait_in = 1'b1;
            end else if (!status.mod_busy) begin
               cmd.do_mult = 1'b1;
               wait_in = 1'b0;
               state_in = status.bit_last ? cnt_pkg::ST_CHECK : cnt_pkg::ST_SQUARE;
            end
         end
         cnt_pkg::ST_CHECK: begin
            // advance to the next base, or drop out at the first failing one
            if (status.pow_ok) begin
               cmd.base_next = 1'b1;
               state_in = cnt_pkg::ST_BASE;
            end else begin
               cmd.set_result = 1'b1;
               state_in = cnt_pkg::ST_REPORT;
            end
         end
         cnt_pkg::ST_REPORT: begin
            // result strobe is up for this cycle
            state_in = cnt_pkg::ST_IDLE;
         end
         default: state_in = cnt_pkg::ST_IDLE;
      endcase
   end
endmodule

// ----- sv/carmichael_number_test_unit.sv -----
// Carmichael number test unit: top level joining controller and datapath.
// Uses cnt_pkg, cnt_ctrl and cnt_datapath.
//
// After reset the unit clears and then sieves a 64K-entry composite map (each candidate
// is read and checked, and each prime then marks its multiples), holding busy high.
// A prime, 0 or 1 is answered straight from the map lookup. A composite walks
// bases 2..n-2 and stops at the first failing base; each base takes 16 exponent
// bits, each a squaring and a multiplication through a bit-serial reduction.
// One result is strobed on rsp_valid for a single cycle; the receiver cannot stall it.
module carmichael_number_test_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [cnt_pkg::NBits-1:0] req_number,
   output logic                      rsp_valid,
   output logic [cnt_pkg::NBits-1:0] rsp_tested_number,
   output logic                      rsp_is_carmichael
);
   cnt_pkg::cmd_type    cmd;
   cnt_pkg::status_type status;

   cnt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   cnt_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_number        (req_number),
      .status            (status),
      .rsp_tested_number (rsp_tested_number),
      .rsp_is_carmichael (rsp_is_carmichael),
      .rsp_valid         (rsp_valid)
   );

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy || $past(busy))
      else $error("result strobe outside a test");
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("busy did not rise after a transfer");
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
endmodule

// ----- verif/tb_top.sv -----
// Testbench for carmichael_number_test_unit: directed and random numbers checked
// against a predictor built on its own sieve. Depends on cnt_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_top;
   localparam int NBits = cnt_pkg::NBits;
   localparam int MapDepth = cnt_pkg::MapDepth;
   localparam int WatchLimit = 3000000;
   localparam int MaxCheapBases = 4;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [NBits-1:0] req_number = '0;
   logic             rsp_valid;
   logic [NBits-1:0] rsp_tested_number;
   logic             rsp_is_carmichael;

   typedef struct {
      logic [NBits-1:0] number;
      logic             carmi;
   } verdict_type;

   verdict_type pending_verdicts[$];
   bit          composite_bits[MapDepth];
   int          gap_pct = 0;
   int          mismatch_count = 0;
   int          sent_count = 0;
   int          carmi_seen = 0;
   int          idle_cycles = 0;

   carmichael_number_test_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_number(req_number), .rsp_valid(rsp_valid),
      .rsp_tested_number(rsp_tested_number), .rsp_is_carmichael(rsp_is_carmichael)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void build_sieve();
      for (int k = 0; k < MapDepth; k++) composite_bits[k] = 1'b0;
      for (int i = 2; i < MapDepth; i++) begin
         if (!composite_bits[i]) begin
            for (int j = 2 * i; j < MapDepth; j += i) composite_bits[j] = 1'b1;
         end
      end
   endfunction

   function automatic longint unsigned fermat_power(longint unsigned a, longint unsigned e,
                                                    longint unsigned m);
      longint unsigned acc;
      acc = 1 % m;
      for (int b = NBits - 1; b >= 0; b--) begin
         acc = (acc * acc) % m;
         if (e[b]) acc = (acc * a) % m;
      end
      return acc;
   endfunction

   // returns the verdict and how many bases the unit will walk
   function automatic logic carmichael_verdict(logic [NBits-1:0] n, output int bases);
      logic carmi;
      bases = 0;
      carmi = composite_bits[n];
      if (carmi) begin
         for (int a = 2; a + 1 < n; a++) begin
            bases++;
            if (fermat_power(a, n, n) != a) begin
               carmi = 1'b0;
               break;
            end
         end
      end
      return carmi;
   endfunction

   task automatic send_number(logic [NBits-1:0] n);
      int          bases;
      verdict_type v;
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      v.number = n;
      v.carmi = carmichael_verdict(n, bases);
      start <= 1'b1;
      req_number <= n;
      do @(posedge clock); while (busy);
      pending_verdicts.push_back(v);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_directed();
      logic [NBits-1:0] picks[$] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd9,
         16'd15, 16'd341, 16'd561, 16'd65521, 16'd65534, 16'd65535, 16'd32768,
         16'd21845, 16'd43690, 16'd255, 16'd25};
      foreach (picks[k]) send_number(picks[k]);
      drain_results();
   endtask

   // random numbers; skip those whose base walk would run for a long time
   task automatic test_random(int count, int pct);
      logic [NBits-1:0] n;
      int               bases;
      gap_pct = pct;
      for (int k = 0; k < count; k++) begin
         do begin
            n = ($urandom_range(3) == 0) ? NBits'($urandom_range(300))
                                         : NBits'($urandom);
            void'(carmichael_verdict(n, bases));
         end while (bases > MaxCheapBases);
         send_number(n);
      end
      drain_results();
   endtask

   always @(posedge clock) begin
      verdict_type v;
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected result, actual number %0d flag %0b", $time,
                     rsp_tested_number, rsp_is_carmichael);
            mismatch_count++;
         end else begin
            v = pending_verdicts.pop_front();
            if (rsp_is_carmichael) carmi_seen++;
            if (rsp_tested_number !== v.number) begin
               $display("%0t: tested_number expected %0d actual %0d", $time, v.number,
                        rsp_tested_number);
               mismatch_count++;
            end
            if (rsp_is_carmichael !== v.carmi) begin
               $display("%0t: is_carmichael for %0d expected %0b actual %0b", $time,
                        v.number, v.carmi, rsp_is_carmichael);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog: count cycles without any transfer or result
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      build_sieve();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(30, 26);
      test_random(30, 53);
      test_random(24, 0);
      $display("Sent %0d numbers (directed extremes, primes, composites, pseudoprimes)",
               sent_count);
      $display("with sender gaps on and off; %0d Carmichael verdicts seen", carmi_seen);
      if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
